// File: design/ils_pkg.sv
// Shared constants and types for the indexed list store.
package ils_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int WORD_BITS_DEF = 32;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_APPEND = 3'd0;
    localparam t_mode MODE_INSERT = 3'd1;
    localparam t_mode MODE_REMOVE = 3'd2;
    localparam t_mode MODE_WRITE  = 3'd3;
    localparam t_mode MODE_READ   = 3'd4;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

// File: design/indexed_list_store_top.sv
// Indexed list store: bounded ordered list kept in one synchronous RAM.
// Append, overwrite, unused modes and errors give the result in the cycle after start;
// read passes through the read state first. Insert and remove move one entry per cycle
// through the RAM port in the shift state before the result is given.
// busy is high while in the shift or read state, so a new transaction is taken once the result
// strobe is shown; the strobe cannot be held off. Synchronous active-low reset empties the list.
module indexed_list_store_top
    import ils_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic signed [31:0] o_read_value,
    output logic [8:0]         o_count,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > 8) ? CW : 8;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [WORD_BITS-1:0] mem [CAPACITY];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [1:0]           r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_left, n_left;
    logic [AW-1:0]        r_src, n_src;
    logic [AW-1:0]        r_dst, n_dst;
    logic                 r_pend, n_pend;
    logic                 r_ins, n_ins;
    logic [AW-1:0]        r_pos, n_pos;
    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_strobe, n_strobe;
    logic signed [31:0]   r_rdv, n_rdv;
    logic [8:0]           r_count, n_count;
    t_status              r_status, n_status;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;

    logic [LW-1:0]        pos_l;
    logic [LW-1:0]        cnt_l;
    logic                 full;
    logic [WORD_BITS-1:0] in_word;

    assign pos_l   = LW'(i_position);
    assign cnt_l   = LW'(r_cnt);
    assign full    = (r_cnt == CW'(CAPACITY));
    assign in_word = WORD_BITS'($unsigned(i_value));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_src    = r_src;
        n_dst    = r_dst;
        n_pend   = r_pend;
        n_ins    = r_ins;
        n_pos    = r_pos;
        n_word   = r_word;
        n_strobe = 1'b0;
        n_rdv    = '0;
        n_count  = 9'(r_cnt);
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = AW'(pos_l);
        wr_data  = in_word;
        rd_addr  = AW'(pos_l);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pos  = AW'(pos_l);
                    n_word = in_word;
                    n_pend = 1'b0;
                    case (i_mode)
                        MODE_APPEND: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_cnt);
                                n_cnt   = r_cnt + 1'b1;
                                n_count = 9'(r_cnt + 1'b1);
                            end
                        end
                        MODE_INSERT: begin
                            if (pos_l > cnt_l) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else if (full) begin
                                n_strobe = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_ins   = 1'b1;
                                n_left  = r_cnt - CW'(pos_l);
                                n_src   = AW'(r_cnt - 1'b1);
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_REMOVE: begin
                            if (pos_l >= cnt_l) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_ins   = 1'b0;
                                n_left  = r_cnt - CW'(pos_l) - 1'b1;
                                n_src   = AW'(pos_l) + 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        MODE_WRITE: begin
                            n_strobe = 1'b1;
                            if (pos_l >= cnt_l) begin
                                n_status = ST_RANGE;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end
                        MODE_READ: begin
                            if (pos_l >= cnt_l) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                rd_addr = r_src;
                n_pend  = 1'b0;
                // read one entry ahead, write it to its neighbor next cycle
                if (r_left != '0) begin
                    n_pend = 1'b1;
                    n_dst  = r_ins ? r_src + 1'b1 : r_src - 1'b1;
                    n_src  = r_ins ? r_src - 1'b1 : r_src + 1'b1;
                    n_left = r_left - 1'b1;
                end
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst;
                    wr_data = r_rd_data;
                end
                if (r_left == '0 && !r_pend) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_ins) begin
                        wr_en   = 1'b1;
                        wr_addr = r_pos;
                        wr_data = r_word;
                        n_cnt   = r_cnt + 1'b1;
                        n_count = 9'(r_cnt + 1'b1);
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_count = 9'(r_cnt - 1'b1);
                    end
                end
            end
            S_READ: begin
                n_strobe = 1'b1;
                n_rdv    = 32'(r_rd_data);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_ins    <= n_ins;
        r_pos    <= n_pos;
        r_word   <= n_word;
        r_rdv    <= n_rdv;
        r_count  <= n_count;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_rdv;
    assign o_count      = r_count;
    assign o_status     = r_status;

endmodule
